// ----- rtl/core/mma_pkg.sv -----
// Shared types and constants for the matrix multiply-accumulate block.
`timescale 1ns / 1ps
package mma_pkg;

  localparam int PADDR_W = 5;
  localparam int DIM_W = 5;
  localparam int IDX_W = 4;
  localparam int DATA_W = 32;
  localparam int RESULT_LIMIT = 16;
  // exact sum of up to 31 products of two 32-bit words
  localparam int ACC_W = 69;
  // alpha * sum plus beta * C aligned to 48 fraction bits
  localparam int TOT_W = 101;
  localparam int Q_W = TOT_W - 32;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_LOAD_C  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_ROW_COUNT   = 3'd0,
    REG_COL_COUNT   = 3'd1,
    REG_INNER_COUNT = 3'd2,
    REG_ALPHA_GAIN  = 3'd3,
    REG_BETA_GAIN   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_MAC       = 3'd0,
    OP_ALPHA_LO  = 3'd1,
    OP_ALPHA_MID = 3'd2,
    OP_ALPHA_HI  = 3'd3,
    OP_BETA      = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_WAIT_SUM,
    S_SCALE,
    S_WAIT_TOT,
    S_ROUND,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0]  row_count;
    logic [DIM_W-1:0]  col_count;
    logic [DIM_W-1:0]  inner_count;
    logic [DATA_W-1:0] alpha_gain;
    logic [DATA_W-1:0] beta_gain;
  } cfg_t;

  typedef struct packed {
    logic issue;
    op_e  op;
    logic clr;
    logic round;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

endpackage

// ----- rtl/core/mma_cmd_if.sv -----
// Command channel: loads and compute-row requests.
`timescale 1ns / 1ps
interface mma_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  row_index;
  logic [3:0]  col_index;
  logic [31:0] elem_value;

  modport source (output valid, cmd, row_index, col_index, elem_value, input ready);
  modport sink (input valid, cmd, row_index, col_index, elem_value, output ready);
endinterface

// ----- rtl/core/mma_res_if.sv -----
// Result channel: one new C element per transfer.
`timescale 1ns / 1ps
interface mma_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_row;
  logic [3:0]  out_col;
  logic [31:0] out_value;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, out_row, out_col, out_value, status, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, status, last, output ready);
endinterface

// ----- rtl/core/matrix_multiply_accumulate.sv -----
// Top level: fixed-point C = alpha*A*B + beta*C over three element RAMs.
`timescale 1ns / 1ps
// Usage:
//   cmd_i carries load and compute-row commands; res_o returns new C elements.
//   Loads of A, B or C give no result. Loads outside the
//   store bounds are dropped.
//   A compute-row command walks every column j < col_count. Each element
//   accumulates inner_count products on the single shared multiplier, then
//   a pipeline drain, four scaling multiplies (alpha in three slices, beta on
//   old C), another drain, rounding and write-back.
//   A bad dimension or row gives a single error result.
//   cmd_i.ready is high only between commands; results sit in a one-entry
//   output register, so the next command is taken while the final result of
//   a row still waits. A stalled receiver holds the row at its next element.
//   Reset clears the control state and sets the registers to their defaults;
//   the RAMs are not cleared, every entry must be loaded before it is read.
//   Configuration goes through the APB port at byte address 4*i; the user
//   must write it only while the block is idle, the block does not enforce it.
module matrix_multiply_accumulate #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int MAX_INNER = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mma_cmd_if.sink                     cmd_i,
  mma_res_if.source                   res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mma_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int C_AW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

  mma_pkg::cfg_t     cfg;
  mma_pkg::mac_ctl_t mac_ctl;
  mma_pkg::mac_sts_t mac_sts;

  mma_pkg::state_e state_q, state_d;
  logic [3:0]      row_q, row_d;
  logic [3:0]      j_q, j_d;
  logic [4:0]      p_q, p_d;
  logic [1:0]      scale_q, scale_d;

  logic             out_valid_q, out_valid_d;
  logic [3:0]       out_row_q, out_row_d;
  logic [3:0]       out_col_q, out_col_d;
  logic [31:0]      out_value_q, out_value_d;
  mma_pkg::status_e out_status_q, out_status_d;
  logic             out_last_q, out_last_d;

  logic            cmd_xfer, is_compute, bad_dim, out_free, col_last;
  logic            a_we, b_we, c_we;
  logic [A_AW-1:0] a_waddr, a_raddr;
  logic [B_AW-1:0] b_waddr, b_raddr;
  logic [C_AW-1:0] c_waddr, c_raddr;
  logic [31:0]     c_wdata;
  logic [31:0]     a_rdata, b_rdata, c_rdata;
  logic [31:0]     elem_value;
  logic            elem_sat;

  mma_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mma_ram #(.WIDTH(32), .DEPTH(A_DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (cmd_i.elem_value),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mma_ram #(.WIDTH(32), .DEPTH(B_DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (cmd_i.elem_value),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mma_ram #(.WIDTH(32), .DEPTH(C_DEPTH)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  mma_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mac_ctl),
    .alpha_i      (cfg.alpha_gain),
    .beta_i       (cfg.beta_gain),
    .a_rdata_i    (a_rdata),
    .b_rdata_i    (b_rdata),
    .c_rdata_i    (c_rdata),
    .sts_o        (mac_sts),
    .elem_value_o (elem_value),
    .elem_sat_o   (elem_sat)
  );

  assign cmd_i.ready = (state_q == mma_pkg::S_IDLE);
  assign cmd_xfer    = cmd_i.valid & cmd_i.ready;
  assign is_compute  = (cmd_i.cmd == mma_pkg::CMD_COMPUTE);
  assign out_free    = !out_valid_q || res_o.ready;
  assign col_last    = (5'(j_q) + 5'd1 == cfg.col_count);

  assign bad_dim = (cfg.row_count == '0) || (cfg.col_count == '0) ||
                   (cfg.inner_count == '0) ||
                   (int'(cfg.row_count) > MAX_ROWS) ||
                   (int'(cfg.col_count) > MAX_COLS) ||
                   (int'(cfg.col_count) > mma_pkg::RESULT_LIMIT) ||
                   (int'(cfg.inner_count) > MAX_INNER) ||
                   ({1'b0, cmd_i.row_index} >= cfg.row_count);

  assign a_raddr = A_AW'(int'(row_q) * MAX_INNER + int'(p_q));
  assign b_raddr = B_AW'(int'(p_q) * MAX_COLS + int'(j_q));
  assign c_raddr = C_AW'(int'(row_q) * MAX_COLS + int'(j_q));
  assign a_waddr = A_AW'(int'(cmd_i.row_index) * MAX_INNER + int'(cmd_i.col_index));
  assign b_waddr = B_AW'(int'(cmd_i.row_index) * MAX_COLS + int'(cmd_i.col_index));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mma_pkg::S_IDLE: begin
        if (cmd_xfer && is_compute) begin
          state_d = bad_dim ? mma_pkg::S_ERR : mma_pkg::S_MAC;
        end
      end
      mma_pkg::S_MAC: begin
        if (p_q + 5'd1 == cfg.inner_count) begin
          state_d = mma_pkg::S_WAIT_SUM;
        end
      end
      mma_pkg::S_WAIT_SUM: begin
        if (!mac_sts.busy) begin
          state_d = mma_pkg::S_SCALE;
        end
      end
      mma_pkg::S_SCALE: begin
        if (scale_q == 2'd3) begin
          state_d = mma_pkg::S_WAIT_TOT;
        end
      end
      mma_pkg::S_WAIT_TOT: begin
        if (!mac_sts.busy) begin
          state_d = mma_pkg::S_ROUND;
        end
      end
      mma_pkg::S_ROUND: state_d = mma_pkg::S_EMIT;
      mma_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = col_last ? mma_pkg::S_IDLE : mma_pkg::S_MAC;
        end
      end
      mma_pkg::S_ERR: begin
        if (out_free) begin
          state_d = mma_pkg::S_IDLE;
        end
      end
      default: state_d = mma_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    row_d         = row_q;
    j_d           = j_q;
    p_d           = '0;
    scale_d       = '0;
    mac_ctl.issue = 1'b0;
    mac_ctl.op    = mma_pkg::OP_MAC;
    mac_ctl.clr   = 1'b0;
    mac_ctl.round = 1'b0;
    a_we          = 1'b0;
    b_we          = 1'b0;
    c_we          = 1'b0;
    c_waddr       = c_raddr;
    c_wdata       = elem_value;
    out_valid_d   = out_valid_q & ~res_o.ready;
    out_row_d     = out_row_q;
    out_col_d     = out_col_q;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;
    out_last_d    = out_last_q;

    unique case (state_q)
      mma_pkg::S_IDLE: begin
        j_d = '0;
        if (cmd_xfer) begin
          row_d   = cmd_i.row_index;
          c_waddr = C_AW'(int'(cmd_i.row_index) * MAX_COLS + int'(cmd_i.col_index));
          c_wdata = cmd_i.elem_value;
          case (cmd_i.cmd)
            mma_pkg::CMD_LOAD_A: a_we = (int'(cmd_i.row_index) < MAX_ROWS) &&
                                        (int'(cmd_i.col_index) < MAX_INNER);
            mma_pkg::CMD_LOAD_B: b_we = (int'(cmd_i.row_index) < MAX_INNER) &&
                                        (int'(cmd_i.col_index) < MAX_COLS);
            mma_pkg::CMD_LOAD_C: c_we = (int'(cmd_i.row_index) < MAX_ROWS) &&
                                        (int'(cmd_i.col_index) < MAX_COLS);
            default:             mac_ctl.clr = 1'b1;
          endcase
        end
      end
      mma_pkg::S_MAC: begin
        mac_ctl.issue = 1'b1;
        p_d           = p_q + 5'd1;
      end
      mma_pkg::S_SCALE: begin
        mac_ctl.issue = 1'b1;
        scale_d       = scale_q + 2'd1;
        unique case (scale_q)
          2'd0:    mac_ctl.op = mma_pkg::OP_ALPHA_LO;
          2'd1:    mac_ctl.op = mma_pkg::OP_ALPHA_MID;
          2'd2:    mac_ctl.op = mma_pkg::OP_ALPHA_HI;
          default: mac_ctl.op = mma_pkg::OP_BETA;
        endcase
      end
      mma_pkg::S_ROUND: mac_ctl.round = 1'b1;
      mma_pkg::S_EMIT: begin
        if (out_free) begin
          c_we         = 1'b1;
          out_valid_d  = 1'b1;
          out_row_d    = row_q;
          out_col_d    = j_q;
          out_value_d  = elem_value;
          out_status_d = elem_sat ? mma_pkg::STATUS_SATURATED : mma_pkg::STATUS_OK;
          out_last_d   = col_last;
          j_d          = j_q + 4'd1;
          mac_ctl.clr  = 1'b1;
        end
      end
      mma_pkg::S_ERR: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_row_d    = row_q;
          out_col_d    = '0;
          out_value_d  = '0;
          out_status_d = mma_pkg::STATUS_INVALID;
          out_last_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mma_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      j_q         <= '0;
      p_q         <= '0;
      scale_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      j_q         <= j_d;
      p_q         <= p_d;
      scale_q     <= scale_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    out_row_q    <= out_row_d;
    out_col_q    <= out_col_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_row   = out_row_q;
  assign res_o.out_col   = out_col_q;
  assign res_o.out_value = out_value_q;
  assign res_o.status    = out_status_q;
  assign res_o.last      = out_last_q;

  a_idle_mac_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mma_pkg::S_IDLE |-> !mac_sts.busy)
    else $error("multiplier pipeline busy while idle");

  a_round_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.round |-> !mac_sts.busy)
    else $error("rounding before accumulation finished");

  a_compute_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_xfer && is_compute |=> state_q != mma_pkg::S_IDLE)
    else $error("compute command dropped");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status == mma_pkg::STATUS_INVALID
      |-> res_o.last && res_o.out_value == 32'd0 && res_o.out_col == 4'd0)
    else $error("malformed error result");

endmodule

// ----- rtl/core/mma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mma_cfg.sv -----
// APB configuration registers: dimensions and gains.
`timescale 1ns / 1ps
module mma_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mma_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mma_pkg::cfg_t               cfg_o
);

  mma_pkg::cfg_t     cfg_q, cfg_d;
  mma_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = mma_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        mma_pkg::REG_ROW_COUNT:   cfg_d.row_count   = pwdata[mma_pkg::DIM_W-1:0];
        mma_pkg::REG_COL_COUNT:   cfg_d.col_count   = pwdata[mma_pkg::DIM_W-1:0];
        mma_pkg::REG_INNER_COUNT: cfg_d.inner_count = pwdata[mma_pkg::DIM_W-1:0];
        mma_pkg::REG_ALPHA_GAIN:  cfg_d.alpha_gain  = pwdata;
        mma_pkg::REG_BETA_GAIN:   cfg_d.beta_gain   = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mma_pkg::REG_ROW_COUNT:   prdata = 32'(cfg_q.row_count);
      mma_pkg::REG_COL_COUNT:   prdata = 32'(cfg_q.col_count);
      mma_pkg::REG_INNER_COUNT: prdata = 32'(cfg_q.inner_count);
      mma_pkg::REG_ALPHA_GAIN:  prdata = cfg_q.alpha_gain;
      mma_pkg::REG_BETA_GAIN:   prdata = cfg_q.beta_gain;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count   <= 5'd16;
      cfg_q.col_count   <= 5'd16;
      cfg_q.inner_count <= 5'd16;
      cfg_q.alpha_gain  <= 32'h0001_0000;
      cfg_q.beta_gain   <= 32'h0000_0000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/mma_mac.sv -----
// Shared 33x33 multiplier with sum and total accumulators, rounding and saturation.
`timescale 1ns / 1ps
module mma_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mma_pkg::mac_ctl_t    ctl_i,
  input  logic [31:0]          alpha_i,
  input  logic [31:0]          beta_i,
  input  logic [31:0]          a_rdata_i,
  input  logic [31:0]          b_rdata_i,
  input  logic [31:0]          c_rdata_i,
  output mma_pkg::mac_sts_t    sts_o,
  output logic [31:0]          elem_value_o,
  output logic                 elem_sat_o
);

  localparam int ACC_W  = mma_pkg::ACC_W;
  localparam int TOT_W  = mma_pkg::TOT_W;
  localparam int Q_W    = mma_pkg::Q_W;
  localparam int MUL_W  = mma_pkg::MUL_W;
  localparam int PROD_W = mma_pkg::PROD_W;

  logic                     v1_q, v2_q;
  mma_pkg::op_e             op1_q, op2_q;
  logic signed [MUL_W-1:0]  opa, opb;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [ACC_W-1:0]         sum_q;
  logic [TOT_W-1:0]         tot_q;
  logic [TOT_W-1:0]         prod_ext, addend, rnd;
  logic [Q_W-1:0]           q_q;
  logic                     neg_q;

  always_comb begin
    opa = '0;
    opb = '0;
    case (op1_q)
      mma_pkg::OP_MAC: begin
        opa = {a_rdata_i[31], a_rdata_i};
        opb = {b_rdata_i[31], b_rdata_i};
      end
      mma_pkg::OP_ALPHA_LO: begin
        opa = {alpha_i[31], alpha_i};
        opb = {1'b0, sum_q[31:0]};
      end
      mma_pkg::OP_ALPHA_MID: begin
        opa = {alpha_i[31], alpha_i};
        opb = {1'b0, sum_q[63:32]};
      end
      mma_pkg::OP_ALPHA_HI: begin
        opa = {alpha_i[31], alpha_i};
        opb = {{(MUL_W-(ACC_W-64)){sum_q[ACC_W-1]}}, sum_q[ACC_W-1:64]};
      end
      mma_pkg::OP_BETA: begin
        opa = {beta_i[31], beta_i};
        opb = {c_rdata_i[31], c_rdata_i};
      end
      default: ;
    endcase
    prod_d = opa * opb;
  end

  assign prod_ext = {{(TOT_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    case (op2_q)
      mma_pkg::OP_ALPHA_MID: addend = prod_ext << 32;
      mma_pkg::OP_ALPHA_HI:  addend = prod_ext << 64;
      mma_pkg::OP_BETA:      addend = prod_ext << 16;
      default:               addend = prod_ext;
    endcase
  end

  // magnitude plus half an LSB of Q16.16; negative side uses ~t + 1
  assign rnd = tot_q[TOT_W-1] ? (~tot_q + TOT_W'(33'h0_8000_0001))
                              : (tot_q + TOT_W'(33'h0_8000_0000));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= ctl_i.op;
    op2_q  <= op1_q;
    prod_q <= prod_d;
    if (ctl_i.clr) begin
      sum_q <= '0;
      tot_q <= '0;
    end else if (v2_q) begin
      if (op2_q == mma_pkg::OP_MAC) begin
        sum_q <= sum_q + prod_ext[ACC_W-1:0];
      end else begin
        tot_q <= tot_q + addend;
      end
    end
    if (ctl_i.round) begin
      neg_q <= tot_q[TOT_W-1];
      q_q   <= rnd[TOT_W-1:32];
    end
  end

  always_comb begin
    if (neg_q) begin
      elem_sat_o   = q_q > Q_W'(33'h0_8000_0000);
      elem_value_o = elem_sat_o ? 32'h8000_0000 : (~q_q[31:0] + 32'd1);
    end else begin
      elem_sat_o   = q_q > Q_W'(32'h7FFF_FFFF);
      elem_value_o = elem_sat_o ? 32'h7FFF_FFFF : q_q[31:0];
    end
  end

  assign sts_o.busy = v1_q | v2_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the fixed-point GEMM block: directed and random command streams.
`timescale 1ns / 1ps
module testbench;
  import mma_pkg::*;

  localparam int DIM = 16;
  localparam int IDLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 150;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    status_e     status;
    logic        last;
  } c_elem_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mma_cmd_if cmd_bus ();
  mma_res_if res_bus ();

  matrix_multiply_accumulate u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cmd_i   (cmd_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [31:0] a_mem [DIM*DIM];
  logic [31:0] b_mem [DIM*DIM];
  logic [31:0] c_mem [DIM*DIM];
  bit a_set [DIM*DIM];
  bit b_set [DIM*DIM];
  bit c_set [DIM*DIM];
  logic [DIM_W-1:0] rows_cfg = 5'd16;
  logic [DIM_W-1:0] cols_cfg = 5'd16;
  logic [DIM_W-1:0] inner_cfg = 5'd16;
  logic signed [31:0] alpha_cfg = 32'sh0001_0000;
  logic signed [31:0] beta_cfg = 32'sh0;

  c_elem_t c_expected [$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned ready_gap = 0;
  bit steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned rand_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4, 5, 6: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic bit dims_ok();
    return rows_cfg != 0 && cols_cfg != 0 && inner_cfg != 0 &&
           rows_cfg <= DIM && cols_cfg <= DIM && inner_cfg <= DIM;
  endfunction

  // exact alpha*sum(A*B) + beta*C, rounded half away from zero to Q16.16, saturated
  function automatic logic [31:0] gemm_element(logic [3:0] i, int j, output bit sat);
    logic signed [127:0] acc;
    logic signed [127:0] tot;
    logic [127:0] q;
    longint av;
    longint bv;
    longint bc;
    int p;
    acc = '0;
    for (p = 0; p < inner_cfg; p++) begin
      av = $signed(a_mem[{i, 4'(p)}]);
      bv = $signed(b_mem[{4'(p), 4'(j)}]);
      acc = acc + av * bv;
    end
    tot = acc * alpha_cfg;
    bc = longint'(beta_cfg) * longint'($signed(c_mem[{i, 4'(j)}]));
    tot = tot + (128'(bc) <<< 16);
    sat = 1'b0;
    if (tot < 0) begin
      q = -tot;
      q = (q + 128'h8000_0000) >> 32;
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'h0 - q[31:0];
    end
    q = tot;
    q = (q + 128'h8000_0000) >> 32;
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic void predict_command(cmd_e op, logic [3:0] r, logic [3:0] c,
                                          logic [31:0] v);
    int j;
    bit sat;
    logic [31:0] nv;
    case (op)
      CMD_LOAD_A: begin
        a_mem[{r, c}] = v;
        a_set[{r, c}] = 1'b1;
      end
      CMD_LOAD_B: begin
        b_mem[{r, c}] = v;
        b_set[{r, c}] = 1'b1;
      end
      CMD_LOAD_C: begin
        c_mem[{r, c}] = v;
        c_set[{r, c}] = 1'b1;
      end
      CMD_COMPUTE: begin
        if (!dims_ok() || r >= rows_cfg) begin
          c_expected.push_back('{r, 4'd0, 32'd0, STATUS_INVALID, 1'b1});
        end else begin
          for (j = 0; j < cols_cfg; j++) begin
            nv = gemm_element(r, j, sat);
            c_mem[{r, 4'(j)}] = nv;
            c_expected.push_back('{r, 4'(j), nv, sat ? STATUS_SATURATED : STATUS_OK,
                                   j == cols_cfg - 1});
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(string detail);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", detail);
  endfunction

  task automatic send_command(cmd_e op, logic [3:0] r, logic [3:0] c, logic [31:0] v);
    int unsigned gap;
    gap = steady ? 0 : rand_gap();
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.cmd <= op;
    cmd_bus.row_index <= r;
    cmd_bus.col_index <= c;
    cmd_bus.elem_value <= v;
    do @(posedge clk); while (!cmd_bus.ready);
    predict_command(op, r, c, v);
  endtask

  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    while (c_expected.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROW_COUNT: rows_cfg = value[DIM_W-1:0];
      REG_COL_COUNT: cols_cfg = value[DIM_W-1:0];
      REG_INNER_COUNT: inner_cfg = value[DIM_W-1:0];
      REG_ALPHA_GAIN: alpha_cfg = value;
      REG_BETA_GAIN: beta_cfg = value;
      default: ;
    endcase
  endtask

  task automatic configure(logic [4:0] m, logic [4:0] n, logic [4:0] k,
                           logic [31:0] alpha, logic [31:0] beta);
    wait_idle();
    // upper bits of the count registers are don't-care
    write_register(REG_ROW_COUNT, {27'($urandom()), m});
    write_register(REG_COL_COUNT, {27'($urandom()), n});
    write_register(REG_INNER_COUNT, {27'($urandom()), k});
    write_register(REG_ALPHA_GAIN, alpha);
    write_register(REG_BETA_GAIN, beta);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // loads whatever the row still lacks, then issues the compute
  task automatic compute_row(logic [3:0] r);
    int p;
    int j;
    if (dims_ok() && r < rows_cfg) begin
      for (p = 0; p < inner_cfg; p++)
        if (!a_set[{r, 4'(p)}]) send_command(CMD_LOAD_A, r, 4'(p), rand_word());
      for (p = 0; p < inner_cfg; p++)
        for (j = 0; j < cols_cfg; j++)
          if (!b_set[{4'(p), 4'(j)}]) send_command(CMD_LOAD_B, 4'(p), 4'(j), rand_word());
      for (j = 0; j < cols_cfg; j++)
        if (!c_set[{r, 4'(j)}]) send_command(CMD_LOAD_C, r, 4'(j), rand_word());
    end
    send_command(CMD_COMPUTE, r, 4'($urandom()), $urandom());
  endtask

  task automatic test_reset_values();
    compute_row(4'd15);
    compute_row(4'd0);
  endtask

  task automatic test_rounding_ties();
    configure(5'd16, 5'd4, 5'd1, 32'h0000_0001, 32'h0);
    send_command(CMD_LOAD_A, 4'd3, 4'd0, 32'h8000_0000);
    send_command(CMD_LOAD_B, 4'd0, 4'd0, 32'h0000_0001);
    send_command(CMD_LOAD_B, 4'd0, 4'd1, 32'hFFFF_FFFF);
    send_command(CMD_LOAD_B, 4'd0, 4'd2, 32'h7FFF_FFFF);
    send_command(CMD_LOAD_B, 4'd0, 4'd3, 32'h8000_0000);
    compute_row(4'd3);
    // alpha zero, beta one: old C passes through
    configure(5'd16, 5'd4, 5'd1, 32'h0, 32'h0001_0000);
    compute_row(4'd3);
  endtask

  task automatic test_saturation();
    configure(5'd16, 5'd4, 5'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_command(CMD_LOAD_C, 4'd3, 4'd0, 32'h7FFF_FFFF);
    send_command(CMD_LOAD_C, 4'd3, 4'd1, 32'h8000_0000);
    compute_row(4'd3);
    configure(5'd16, 5'd4, 5'd1, 32'h8000_0000, 32'h8000_0000);
    compute_row(4'd3);
  endtask

  task automatic test_bad_dimensions();
    configure(5'd0, 5'd4, 5'd1, 32'h0001_0000, 32'h0);
    compute_row(4'd0);
    configure(5'd31, 5'd4, 5'd1, 32'h0001_0000, 32'h0);
    compute_row(4'd2);
    configure(5'd16, 5'd0, 5'd1, 32'h0001_0000, 32'h0);
    compute_row(4'd1);
    configure(5'd16, 5'd17, 5'd1, 32'h0001_0000, 32'h0);
    compute_row(4'd1);
    configure(5'd16, 5'd4, 5'd0, 32'h0001_0000, 32'h0);
    compute_row(4'd1);
    configure(5'd16, 5'd4, 5'd17, 32'h0001_0000, 32'h0);
    compute_row(4'd1);
    configure(5'd4, 5'd4, 5'd1, 32'h0001_0000, 32'h0001_0000);
    compute_row(4'd4);
    compute_row(4'd15);
    compute_row(4'd3);
    configure(5'd1, 5'd1, 5'd1, 32'h0001_0000, 32'h0);
    compute_row(4'd0);
    compute_row(4'd1);
  endtask

  task automatic test_backpressure();
    int r;
    configure(5'd16, 5'd16, 5'd2, 32'h0001_0000, 32'h0000_8000);
    steady = 1'b1;
    hold_req++;
    for (r = 0; r < 6; r++) compute_row(4'(r));
    wait_idle();
    steady = 1'b0;
    for (r = 6; r < 10; r++) compute_row(4'(r));
    wait_idle();
  endtask

  task automatic pick_config();
    logic [4:0] m;
    logic [4:0] n;
    logic [4:0] k;
    logic [4:0] bad;
    m = $urandom_range(1, 16);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
    k = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) begin
      bad = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
      case ($urandom_range(0, 2))
        0: m = bad;
        1: n = bad;
        default: k = bad;
      endcase
    end
    configure(m, n, k, rand_word(), rand_word());
  endtask

  task automatic random_sequence(output int unsigned sent);
    int unsigned n;
    int unsigned kmax;
    int unsigned nmax;
    logic [3:0] r;
    sent = 0;
    kmax = (inner_cfg >= 1 && inner_cfg <= DIM) ? inner_cfg : DIM;
    nmax = (cols_cfg >= 1 && cols_cfg <= DIM) ? cols_cfg : DIM;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom_range(1, 4);
        repeat (n)
          send_command(cmd_e'($urandom_range(0, 2)), 4'($urandom()), 4'($urandom()),
                       rand_word());
        sent = n;
      end
      2: begin
        compute_row(4'($urandom()));
        sent = 1;
      end
      default: begin
        r = (rows_cfg >= 1 && rows_cfg <= DIM) ? 4'($urandom_range(0, rows_cfg - 1))
                                               : 4'($urandom());
        n = $urandom_range(0, 3);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: send_command(CMD_LOAD_A, r, 4'($urandom_range(0, kmax - 1)), rand_word());
            1: send_command(CMD_LOAD_B, 4'($urandom_range(0, kmax - 1)),
                            4'($urandom_range(0, nmax - 1)), rand_word());
            default: send_command(CMD_LOAD_C, r, 4'($urandom_range(0, nmax - 1)),
                                  rand_word());
          endcase
        end
        compute_row(r);
        sent = n + 1;
      end
    endcase
  endtask

  task automatic test_random_stream();
    int unsigned done;
    int unsigned got;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      pick_config();
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 10)) begin
        random_sequence(got);
        done += got;
      end
    end
    steady = 1'b0;
  endtask

  // result receiver: random gaps at any phase, long hold-off on request
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
      if (!steady && $urandom_range(0, 2) == 0) ready_gap = rand_gap();
    end
  end

  always @(posedge clk) begin : check_results
    c_elem_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (c_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer row %0d col %0d value %h status %0d",
                                res_bus.out_row, res_bus.out_col, res_bus.out_value,
                                res_bus.status));
      end else begin
        want = c_expected.pop_front();
        if (res_bus.out_row !== want.row || res_bus.out_col !== want.col ||
            res_bus.out_value !== want.value || res_bus.status !== want.status ||
            res_bus.last !== want.last)
          flag_mismatch($sformatf(
              "exp row %0d col %0d value %h status %0d last %0d, got %0d %0d %h %0d %0d",
              want.row, want.col, want.value, want.status, want.last,
              res_bus.out_row, res_bus.out_col, res_bus.out_value, res_bus.status,
              res_bus.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (psel && penable))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[matrix_multiply_accumulate] ERROR");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.cmd = CMD_LOAD_A;
    cmd_bus.row_index = '0;
    cmd_bus.col_index = '0;
    cmd_bus.elem_value = '0;
    res_bus.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_rounding_ties();
    test_saturation();
    test_bad_dimensions();
    test_backpressure();
    test_random_stream();
    wait_idle();
    if (mismatch_count == 0 && c_expected.size() == 0)
      $display("[matrix_multiply_accumulate] OK");
    else
      $display("[matrix_multiply_accumulate] ERROR");
    $finish;
  end

endmodule
